[rtl/rsf_pkg.sv]
// shared constants, types and arithmetic helpers for the shape function block
`default_nettype none
package rsf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 18;

    localparam int KIND_W = 3;
    localparam int NODE_W = 3;

    // factor 1 +/- x is kept two bits wider than the value width
    localparam int FACT_W  = VALUE_WIDTH + 2;
    localparam int PROD_W  = 2 * FACT_W;
    localparam int MID_W   = PROD_W - FRAC_BITS;
    localparam int MPROD_W = MID_W + FACT_W;
    localparam int WIDE_W  = MPROD_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [KIND_W-1:0] KIND_EDGE2 = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TRI3  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUAD4 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TET4  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HEX8  = 3'd4;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [FACT_W-1:0]      fact_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [MID_W-1:0]       mid_t;
    typedef logic signed [MPROD_W-1:0]     mprod_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;

    typedef struct packed {
        value_t              r;
        value_t              s;
        value_t              t;
        logic [KIND_W-1:0]   kind;
        logic [NODE_W-1:0]   last_node;
    } point_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] node;
        logic              last;
        logic              a_pos;
        logic              b_pos;
        logic              c_pos;
    } node_ctl_t;

    // round to nearest with halves upward, sh >= 1
    function automatic wide_t rnd(input wide_t x, input int sh);
        wide_t bias;
        bias = wide_t'(1) <<< (sh - 1);
        return (x + bias) >>> sh;
    endfunction

    // clamp to the signed output range
    function automatic value_t sat_out(input wide_t x);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (VALUE_WIDTH - 1)) - wide_t'(1);
        lo = -(wide_t'(1) <<< (VALUE_WIDTH - 1));
        if (x > hi) begin
            return hi[VALUE_WIDTH-1:0];
        end else if (x < lo) begin
            return lo[VALUE_WIDTH-1:0];
        end
        return x[VALUE_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/reference_shape_functions.sv]
// top level: linear shape functions and gradients for one reference point
// each node result passes the factor, product and triple product stages and the output register
// one node result per cycle while the result is not stalled; a point gives 2, 3, 4, 4 or 8 results
// (edge, tri, quad, tet, hex), stepped through by the node sequencer in the back end
// points under an undefined element kind are accepted when the queue has room and give nothing
// reset: element kind returns to edge2, point queue and pipeline are emptied
`default_nettype none
module reference_shape_functions (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration write channel, element kind only
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rsf_pkg::KIND_W-1:0]  cfg_data,
    // point input channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire rsf_pkg::value_t             s_coord_r,
    input  wire rsf_pkg::value_t             s_coord_s,
    input  wire rsf_pkg::value_t             s_coord_t,
    // node result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [rsf_pkg::NODE_W-1:0]       m_node,
    output rsf_pkg::value_t                  m_weight,
    output rsf_pkg::value_t                  m_grad_r,
    output rsf_pkg::value_t                  m_grad_s,
    output rsf_pkg::value_t                  m_grad_t,
    output logic                             m_last
);

    // front to queue
    logic            push_valid;
    logic            push_ready;
    rsf_pkg::point_t push_data;

    // queue to back end
    logic            head_valid;
    logic            head_ready;
    rsf_pkg::point_t head_data;

    // front end latches the element kind with each point so that a
    // transaction already queued keeps the kind it was accepted under
    rsf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_coord_r  (s_coord_r),
        .s_coord_s  (s_coord_s),
        .s_coord_t  (s_coord_t),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // two-entry queue lets the front keep accepting while the back end
    // is still stepping through the nodes of an earlier point
    rsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (head_valid),
        .out_ready (head_ready),
        .out_data  (head_data)
    );

    // back end issues one node a cycle into a four-stage pipeline whose
    // last stage is the output register; a stalled result holds the pipe
    rsf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_data  (head_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_node     (m_node),
        .m_weight   (m_weight),
        .m_grad_r   (m_grad_r),
        .m_grad_s   (m_grad_s),
        .m_grad_t   (m_grad_t),
        .m_last     (m_last)
    );

endmodule
`default_nettype wire

[rtl/rsf_front.sv]
// front end: element kind register, point acceptance and classification
`default_nettype none
module rsf_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rsf_pkg::KIND_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire rsf_pkg::value_t                s_coord_r,
    input  wire rsf_pkg::value_t                s_coord_s,
    input  wire rsf_pkg::value_t                s_coord_t,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output rsf_pkg::point_t                     push_data
);

    logic [rsf_pkg::KIND_W-1:0] element_kind_reg;
    logic [rsf_pkg::KIND_W-1:0] element_kind_next;
    logic                       kind_known;
    logic [rsf_pkg::NODE_W-1:0] last_node;

    assign cfg_ready = 1'b1;

    always_comb begin
        element_kind_next = element_kind_reg;
        if (cfg_valid) begin
            element_kind_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_kind_reg <= rsf_pkg::KIND_EDGE2;
        end else begin
            element_kind_reg <= element_kind_next;
        end
    end

    // number of nodes less one; unknown kinds are dropped on acceptance
    always_comb begin
        kind_known = 1'b1;
        last_node  = '0;
        unique case (element_kind_reg)
            rsf_pkg::KIND_EDGE2: last_node = 3'd1;
            rsf_pkg::KIND_TRI3:  last_node = 3'd2;
            rsf_pkg::KIND_QUAD4: last_node = 3'd3;
            rsf_pkg::KIND_TET4:  last_node = 3'd3;
            rsf_pkg::KIND_HEX8:  last_node = 3'd7;
            default:             kind_known = 1'b0;
        endcase
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid && kind_known;

    always_comb begin
        push_data.r         = s_coord_r;
        push_data.s         = s_coord_s;
        push_data.t         = s_coord_t;
        push_data.kind      = element_kind_reg;
        push_data.last_node = last_node;
    end

endmodule
`default_nettype wire

[rtl/rsf_queue.sv]
// short point queue between front and back end
`default_nettype none
module rsf_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rsf_pkg::point_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rsf_pkg::point_t      out_data
);

    localparam int CNT_W = rsf_pkg::QPTR_W + 1;

    rsf_pkg::point_t             entry_reg [rsf_pkg::QUEUE_DEPTH];
    logic [rsf_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rsf_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        push, pop;

    assign in_ready  = (count_reg != CNT_W'(rsf_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rsf_pkg::QPTR_W'(rsf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == rsf_pkg::QPTR_W'(rsf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

[rtl/rsf_back.sv]
// back end: node sequencer and shape function evaluation pipeline
`default_nettype none
module rsf_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        head_valid,
    output logic                             head_ready,
    input  wire rsf_pkg::point_t             head_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [rsf_pkg::NODE_W-1:0]       m_node,
    output rsf_pkg::value_t                  m_weight,
    output rsf_pkg::value_t                  m_grad_r,
    output rsf_pkg::value_t                  m_grad_s,
    output rsf_pkg::value_t                  m_grad_t,
    output logic                             m_last
);

    localparam rsf_pkg::fact_t ONE_F  = rsf_pkg::fact_t'(1) <<< rsf_pkg::FRAC_BITS;
    localparam rsf_pkg::wide_t ONE_W  = rsf_pkg::wide_t'(1) <<< rsf_pkg::FRAC_BITS;
    localparam rsf_pkg::wide_t HALF_W = rsf_pkg::wide_t'(1) <<< (rsf_pkg::FRAC_BITS - 1);

    logic                       en;
    logic                       issue;
    logic [rsf_pkg::NODE_W-1:0] node_cnt_reg, node_cnt_next;
    rsf_pkg::node_ctl_t         ctl0;
    rsf_pkg::fact_t             fa0, fb0, fc0;

    // stage 1: factors
    logic                v1_reg;
    rsf_pkg::node_ctl_t  ctl1_reg;
    rsf_pkg::value_t     r1_reg, s1_reg, t1_reg;
    rsf_pkg::fact_t      fa1_reg, fb1_reg, fc1_reg;

    // stage 2: pairwise products
    logic                v2_reg;
    rsf_pkg::node_ctl_t  ctl2_reg;
    rsf_pkg::value_t     r2_reg, s2_reg, t2_reg;
    rsf_pkg::fact_t      fa2_reg, fb2_reg, fc2_reg;
    rsf_pkg::prod_t      pab2_reg, pbc2_reg, pac2_reg;

    // stage 3: triple product for the hex weight
    logic                v3_reg;
    rsf_pkg::node_ctl_t  ctl3_reg;
    rsf_pkg::value_t     r3_reg, s3_reg, t3_reg;
    rsf_pkg::fact_t      fa3_reg, fb3_reg;
    rsf_pkg::prod_t      pab3_reg, pbc3_reg, pac3_reg;
    rsf_pkg::mprod_t     mfc3_reg;
    rsf_pkg::wide_t      mid_round;
    rsf_pkg::mid_t       mid2;

    // output register
    logic                out_valid_reg;
    rsf_pkg::wide_t      wr, ws, wt, wfa, wfb, wab, wbc, wac, wmfc;
    rsf_pkg::wide_t      w_res, gr_res, gs_res, gt_res;

    assign en         = !out_valid_reg || m_ready;
    assign issue      = head_valid && en;
    assign head_ready = issue && (node_cnt_reg == head_data.last_node);

    always_comb begin
        node_cnt_next = node_cnt_reg;
        if (head_ready) begin
            node_cnt_next = '0;
        end else if (issue) begin
            node_cnt_next = node_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_cnt_reg <= '0;
        end else begin
            node_cnt_reg <= node_cnt_next;
        end
    end

    // corner signs from the node index
    always_comb begin
        ctl0.kind  = head_data.kind;
        ctl0.node  = node_cnt_reg;
        ctl0.last  = (node_cnt_reg == head_data.last_node);
        ctl0.a_pos = node_cnt_reg[0] ^ node_cnt_reg[1];
        ctl0.b_pos = node_cnt_reg[1];
        ctl0.c_pos = node_cnt_reg[2];
        fa0 = ctl0.a_pos ? ONE_F + rsf_pkg::fact_t'(head_data.r)
                         : ONE_F - rsf_pkg::fact_t'(head_data.r);
        fb0 = ctl0.b_pos ? ONE_F + rsf_pkg::fact_t'(head_data.s)
                         : ONE_F - rsf_pkg::fact_t'(head_data.s);
        fc0 = ctl0.c_pos ? ONE_F + rsf_pkg::fact_t'(head_data.t)
                         : ONE_F - rsf_pkg::fact_t'(head_data.t);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign mid_round = rsf_pkg::rnd(rsf_pkg::wide_t'(pab2_reg), rsf_pkg::FRAC_BITS);
    assign mid2      = mid_round[rsf_pkg::MID_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl1_reg <= ctl0;
            r1_reg   <= head_data.r;
            s1_reg   <= head_data.s;
            t1_reg   <= head_data.t;
            fa1_reg  <= fa0;
            fb1_reg  <= fb0;
            fc1_reg  <= fc0;

            ctl2_reg <= ctl1_reg;
            r2_reg   <= r1_reg;
            s2_reg   <= s1_reg;
            t2_reg   <= t1_reg;
            fa2_reg  <= fa1_reg;
            fb2_reg  <= fb1_reg;
            fc2_reg  <= fc1_reg;
            pab2_reg <= rsf_pkg::prod_t'(fa1_reg) * rsf_pkg::prod_t'(fb1_reg);
            pbc2_reg <= rsf_pkg::prod_t'(fb1_reg) * rsf_pkg::prod_t'(fc1_reg);
            pac2_reg <= rsf_pkg::prod_t'(fa1_reg) * rsf_pkg::prod_t'(fc1_reg);

            ctl3_reg <= ctl2_reg;
            r3_reg   <= r2_reg;
            s3_reg   <= s2_reg;
            t3_reg   <= t2_reg;
            fa3_reg  <= fa2_reg;
            fb3_reg  <= fb2_reg;
            pab3_reg <= pab2_reg;
            pbc3_reg <= pbc2_reg;
            pac3_reg <= pac2_reg;
            mfc3_reg <= rsf_pkg::mprod_t'(mid2) * rsf_pkg::mprod_t'(fc2_reg);
        end
    end

    always_comb begin
        wr   = rsf_pkg::wide_t'(r3_reg);
        ws   = rsf_pkg::wide_t'(s3_reg);
        wt   = rsf_pkg::wide_t'(t3_reg);
        wfa  = rsf_pkg::wide_t'(fa3_reg);
        wfb  = rsf_pkg::wide_t'(fb3_reg);
        wab  = rsf_pkg::wide_t'(pab3_reg);
        wbc  = rsf_pkg::wide_t'(pbc3_reg);
        wac  = rsf_pkg::wide_t'(pac3_reg);
        wmfc = rsf_pkg::wide_t'(mfc3_reg);
        w_res  = '0;
        gr_res = '0;
        gs_res = '0;
        gt_res = '0;
        unique case (ctl3_reg.kind)
            rsf_pkg::KIND_EDGE2: begin
                w_res  = rsf_pkg::rnd(wfa, 1);
                gr_res = ctl3_reg.a_pos ? HALF_W : -HALF_W;
            end
            rsf_pkg::KIND_TRI3, rsf_pkg::KIND_TET4: begin
                // barycentric: node zero takes the remainder
                unique case (ctl3_reg.node)
                    3'd0: begin
                        w_res  = (ctl3_reg.kind == rsf_pkg::KIND_TET4)
                               ? ONE_W - wr - ws - wt : ONE_W - wr - ws;
                        gr_res = -ONE_W;
                        gs_res = -ONE_W;
                        gt_res = (ctl3_reg.kind == rsf_pkg::KIND_TET4) ? -ONE_W : '0;
                    end
                    3'd1: begin
                        w_res  = wr;
                        gr_res = ONE_W;
                    end
                    3'd2: begin
                        w_res  = ws;
                        gs_res = ONE_W;
                    end
                    default: begin
                        w_res  = wt;
                        gt_res = ONE_W;
                    end
                endcase
            end
            rsf_pkg::KIND_QUAD4: begin
                w_res  = rsf_pkg::rnd(wab, rsf_pkg::FRAC_BITS + 2);
                gr_res = rsf_pkg::rnd(ctl3_reg.a_pos ? wfb : -wfb, 2);
                gs_res = rsf_pkg::rnd(ctl3_reg.b_pos ? wfa : -wfa, 2);
            end
            rsf_pkg::KIND_HEX8: begin
                w_res  = rsf_pkg::rnd(wmfc, rsf_pkg::FRAC_BITS + 3);
                gr_res = rsf_pkg::rnd(ctl3_reg.a_pos ? wbc : -wbc, rsf_pkg::FRAC_BITS + 3);
                gs_res = rsf_pkg::rnd(ctl3_reg.b_pos ? wac : -wac, rsf_pkg::FRAC_BITS + 3);
                gt_res = rsf_pkg::rnd(ctl3_reg.c_pos ? wab : -wab, rsf_pkg::FRAC_BITS + 3);
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_node   <= ctl3_reg.node;
            m_last   <= ctl3_reg.last;
            m_weight <= rsf_pkg::sat_out(w_res);
            m_grad_r <= rsf_pkg::sat_out(gr_res);
            m_grad_s <= rsf_pkg::sat_out(gs_res);
            m_grad_t <= rsf_pkg::sat_out(gt_res);
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire
